// ===== sv/tfn_pkg.sv =====
// Shared widths, constants and item types for the triangle face normal block.
package tfn_pkg;

  localparam int CW   = 24;             // vertex coordinate width
  localparam int NW   = 16;             // normal component width
  localparam int FB   = NW - 2;         // normal fraction bits
  localparam int DW   = CW + 1;         // edge vector width
  localparam int PW   = 2 * DW;         // product width
  localparam int TW   = PW + 1;         // cross term width
  localparam int MW   = TW - 1;         // cross term magnitude width
  localparam int SW   = 24;             // magnitude width after scaling
  localparam int SSW  = 2 * SW + 2;     // sum of squares width
  localparam int RW   = SSW / 2;        // square root width
  localparam int DVW  = RW + FB;        // divider working width
  localparam int QW   = FB + 1;         // quotient width
  localparam int MAGW = 16;             // threshold register width
  localparam int CNTW = $clog2(RW);     // sequencer step counter width

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } tri_t;

  typedef struct packed {
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [NW-1:0] normal_x;
    logic signed [NW-1:0] normal_y;
    logic signed [NW-1:0] normal_z;
    logic                 degenerate;
    logic                 last_vertex;
  } vtx_t;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic signed [NW-1:0] z;
    logic                 degenerate;
  } nrm_t;

endpackage

// ===== sv/triangle_face_normal.sv =====
// Top level: edge vectors, three cross product lanes, normalizer and per-vertex output stage.
//
//  channel | signals                         | meaning
//  --------+---------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_tri      | one triangle per item
//  out     | out_valid, out_ready, out_item  | one vertex with normal per item
//  cfg     | cfg_valid, cfg_ready, cfg_data  | min_magnitude register write
//
// Three output items per triangle, one per cycle while out_ready is high.
// The shared normalizer sets the rate: a degenerate triangle skips the root and divide
// steps, and each bit the largest cross term exceeds 24 bits adds one shift step.
// Two cross product stages and the output stage overlap with the normalizer.
// Reset clears valid state and sets min_magnitude to zero; out stalls hold everything.
module triangle_face_normal (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  tfn_pkg::tri_t              in_tri,
  output logic                       out_valid,
  input  logic                       out_ready,
  output tfn_pkg::vtx_t              out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tfn_pkg::MAGW-1:0]   cfg_data
);
  import tfn_pkg::*;

  localparam logic [1:0] K_A = 2'd0;
  localparam logic [1:0] K_B = 2'd1;
  localparam logic [1:0] K_C = 2'd2;

  logic [MAGW-1:0]      min_mag_r;
  logic                 v1_r, v2_r, ob_v_r;
  tri_t                 tri1_r, tri2_r, tri3_r, ob_tri_r;
  nrm_t                 ob_nrm_r;
  logic [1:0]           ob_k_r;
  logic                 adv1, adv2, s2_free, ob_free, in_fire, out_fire, res_take;
  logic signed [DW-1:0] ux, uy, uz, wx, wy, wz;
  logic [MW-1:0]        mag [3];
  logic [2:0]           neg;
  logic                 nm_in_ready, nm_res_valid;
  nrm_t                 nm_res;

  assign ux = {in_tri.b_x[CW-1], in_tri.b_x} - {in_tri.a_x[CW-1], in_tri.a_x};
  assign uy = {in_tri.b_y[CW-1], in_tri.b_y} - {in_tri.a_y[CW-1], in_tri.a_y};
  assign uz = {in_tri.b_z[CW-1], in_tri.b_z} - {in_tri.a_z[CW-1], in_tri.a_z};
  assign wx = {in_tri.c_x[CW-1], in_tri.c_x} - {in_tri.a_x[CW-1], in_tri.a_x};
  assign wy = {in_tri.c_y[CW-1], in_tri.c_y} - {in_tri.a_y[CW-1], in_tri.a_y};
  assign wz = {in_tri.c_z[CW-1], in_tri.c_z} - {in_tri.a_z[CW-1], in_tri.a_z};

  assign ob_free  = !ob_v_r || (out_ready && (ob_k_r == K_C));
  assign res_take = nm_res_valid && ob_free;
  assign adv2     = v2_r && nm_in_ready;
  assign s2_free  = !v2_r || adv2;
  assign adv1     = v1_r && s2_free;
  assign in_ready = !v1_r || adv1;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = ob_v_r && out_ready;

  tfn_cross u_cross_x (
    .clk (clk), .en1 (in_fire), .en2 (adv1),
    .p (uy), .q (wz), .r (uz), .s (wy), .mag (mag[0]), .neg (neg[0])
  );
  tfn_cross u_cross_y (
    .clk (clk), .en1 (in_fire), .en2 (adv1),
    .p (uz), .q (wx), .r (ux), .s (wz), .mag (mag[1]), .neg (neg[1])
  );
  tfn_cross u_cross_z (
    .clk (clk), .en1 (in_fire), .en2 (adv1),
    .p (ux), .q (wy), .r (uy), .s (wx), .mag (mag[2]), .neg (neg[2])
  );

  tfn_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_ready  (nm_in_ready),
    .mag_x     (mag[0]),
    .mag_y     (mag[1]),
    .mag_z     (mag[2]),
    .neg       (neg),
    .min_mag   (min_mag_r),
    .res_valid (nm_res_valid),
    .res_ready (ob_free),
    .res       (nm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      ob_v_r    <= 1'b0;
      ob_k_r    <= K_A;
      min_mag_r <= '0;
    end else begin
      if (cfg_valid) min_mag_r <= cfg_data;
      if (in_fire) v1_r <= 1'b1;
      else if (adv1) v1_r <= 1'b0;
      if (adv1) v2_r <= 1'b1;
      else if (adv2) v2_r <= 1'b0;
      if (res_take) begin
        ob_v_r <= 1'b1;
        ob_k_r <= K_A;
      end else if (out_fire) begin
        if (ob_k_r == K_C) ob_v_r <= 1'b0;
        else ob_k_r <= ob_k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) tri1_r <= in_tri;
    if (adv1) tri2_r <= tri1_r;
    if (adv2) tri3_r <= tri2_r;
    if (res_take) begin
      ob_tri_r <= tri3_r;
      ob_nrm_r <= nm_res;
    end
  end

  always_comb begin
    case (ob_k_r)
      K_A: begin
        out_item.pos_x = ob_tri_r.a_x;
        out_item.pos_y = ob_tri_r.a_y;
        out_item.pos_z = ob_tri_r.a_z;
      end
      K_B: begin
        out_item.pos_x = ob_tri_r.b_x;
        out_item.pos_y = ob_tri_r.b_y;
        out_item.pos_z = ob_tri_r.b_z;
      end
      default: begin
        out_item.pos_x = ob_tri_r.c_x;
        out_item.pos_y = ob_tri_r.c_y;
        out_item.pos_z = ob_tri_r.c_z;
      end
    endcase
    out_item.normal_x    = ob_nrm_r.x;
    out_item.normal_y    = ob_nrm_r.y;
    out_item.normal_z    = ob_nrm_r.z;
    out_item.degenerate  = ob_nrm_r.degenerate;
    out_item.last_vertex = (ob_k_r == K_C);
  end

  assign out_valid = ob_v_r;
  assign cfg_ready = 1'b1;

endmodule

// ===== sv/tfn_cross.sv =====
// One cross product component lane: two products, difference, magnitude and sign.
module tfn_cross (
  input  logic                         clk,
  input  logic                         en1,
  input  logic                         en2,
  input  logic signed [tfn_pkg::DW-1:0] p,
  input  logic signed [tfn_pkg::DW-1:0] q,
  input  logic signed [tfn_pkg::DW-1:0] r,
  input  logic signed [tfn_pkg::DW-1:0] s,
  output logic        [tfn_pkg::MW-1:0] mag,
  output logic                          neg
);
  import tfn_pkg::*;

  logic signed [PW-1:0] pq_r;
  logic signed [PW-1:0] rs_r;
  logic        [TW-1:0] term;
  logic        [TW-1:0] term_abs;
  logic        [MW-1:0] mag_r;
  logic                 neg_r;

  assign term     = {pq_r[PW-1], pq_r} - {rs_r[PW-1], rs_r};
  assign term_abs = term[TW-1] ? (~term + TW'(1)) : term;

  always_ff @(posedge clk) begin
    if (en1) begin
      pq_r <= p * q;
      rs_r <= r * s;
    end
    if (en2) begin
      mag_r <= term_abs[MW-1:0];
      neg_r <= term[TW-1];
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;

endmodule

// ===== sv/tfn_div.sv =====
// One restoring divider lane, one quotient bit per step.
module tfn_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [tfn_pkg::DVW-1:0]       dividend,
  input  logic [tfn_pkg::RW-1:0]        divisor,
  output logic [tfn_pkg::QW-1:0]        quo
);
  import tfn_pkg::*;

  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] dv_r;
  logic [QW-1:0]  q_r;

  always_ff @(posedge clk) begin
    if (load) begin
      rem_r <= dividend;
      dv_r  <= {divisor, FB'(0)};
      q_r   <= '0;
    end else if (step) begin
      if (rem_r >= dv_r) begin
        rem_r <= rem_r - dv_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
  end

  assign quo = q_r;

endmodule

// ===== sv/tfn_norm.sv =====
// Normalization sequencer: scale, sum of squares, threshold, square root, divider lanes.
module tfn_norm (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tfn_pkg::MW-1:0]     mag_x,
  input  logic [tfn_pkg::MW-1:0]     mag_y,
  input  logic [tfn_pkg::MW-1:0]     mag_z,
  input  logic [2:0]                 neg,
  input  logic [tfn_pkg::MAGW-1:0]   min_mag,
  output logic                       res_valid,
  input  logic                       res_ready,
  output tfn_pkg::nrm_t              res
);
  import tfn_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SHIFT  = 8'b0000_0010,
    ST_SQUARE = 8'b0000_0100,
    ST_SUM    = 8'b0000_1000,
    ST_ROOT   = 8'b0001_0000,
    ST_PREP   = 8'b0010_0000,
    ST_DIVIDE = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } st_t;

  localparam int PSH = (FB >= 16) ? FB - 16 : 16 - FB;
  localparam int PTW = 17 + FB + PSH;

  st_t                st_r, st_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [MW-1:0]      m_r [3];
  logic [2:0]         neg_r;
  logic               small_r;
  logic [2*SW-1:0]    sq_r [3];
  logic [2*MAGW-1:0]  mm2_r;
  logic               degen_r;
  logic [RW-1:0]      rt_r;
  logic [RW+1:0]      rrem_r;
  logic [SSW-1:0]     rval_r;
  logic [SSW-1:0]     ss_sum;
  logic [RW+1:0]      rrem_sh;
  logic [RW+1:0]      rtrial;
  logic [RW-1:0]      mroot;
  logic               any_big;
  logic               div_load;
  logic               div_step;
  logic [DVW-1:0]     dvd [3];
  logic [QW-1:0]      quo [3];
  logic [NW-1:0]      nrm [3];
  logic               small_in;

  assign small_in = (mag_x < MW'(65536)) && (mag_y < MW'(65536)) && (mag_z < MW'(65536));
  assign any_big  = (|m_r[0][MW-1:SW]) || (|m_r[1][MW-1:SW]) || (|m_r[2][MW-1:SW]);
  assign ss_sum   = SSW'(sq_r[0]) + SSW'(sq_r[1]) + SSW'(sq_r[2]);
  assign rrem_sh  = {rrem_r[RW-1:0], rval_r[SSW-1:SSW-2]};
  assign rtrial   = {rt_r, 2'b01};
  assign mroot    = (rt_r == '0) ? RW'(1) : rt_r;
  assign div_load = (st_r == ST_PREP);
  assign div_step = (st_r == ST_DIVIDE);

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      ST_IDLE:   if (in_valid) st_nxt = ST_SHIFT;
      ST_SHIFT:  if (!any_big) st_nxt = ST_SQUARE;
      ST_SQUARE: st_nxt = ST_SUM;
      ST_SUM: begin
        cnt_nxt = '0;
        if (small_r && (ss_sum <= SSW'(mm2_r))) st_nxt = ST_DONE;
        else st_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(RW - 1)) st_nxt = ST_PREP;
      end
      ST_PREP: begin
        cnt_nxt = '0;
        st_nxt  = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(FB)) st_nxt = ST_DONE;
      end
      ST_DONE:   if (res_ready) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        m_r[0]  <= mag_x;
        m_r[1]  <= mag_y;
        m_r[2]  <= mag_z;
        neg_r   <= neg;
        small_r <= small_in;
      end
      ST_SHIFT: begin
        if (any_big) begin
          m_r[0] <= m_r[0] >> 1;
          m_r[1] <= m_r[1] >> 1;
          m_r[2] <= m_r[2] >> 1;
        end
      end
      ST_SQUARE: begin
        sq_r[0] <= m_r[0][SW-1:0] * m_r[0][SW-1:0];
        sq_r[1] <= m_r[1][SW-1:0] * m_r[1][SW-1:0];
        sq_r[2] <= m_r[2][SW-1:0] * m_r[2][SW-1:0];
        mm2_r   <= min_mag * min_mag;
      end
      ST_SUM: begin
        degen_r <= small_r && (ss_sum <= SSW'(mm2_r));
        rval_r  <= ss_sum;
        rt_r    <= '0;
        rrem_r  <= '0;
      end
      ST_ROOT: begin
        if (rrem_sh >= rtrial) begin
          rrem_r <= rrem_sh - rtrial;
          rt_r   <= {rt_r[RW-2:0], 1'b1};
        end else begin
          rrem_r <= rrem_sh;
          rt_r   <= {rt_r[RW-2:0], 1'b0};
        end
        rval_r <= rval_r << 2;
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [PTW-1:0] pt_wide;
    logic [QW-1:0]  pt;
    logic [QW-1:0]  qsel;

    assign dvd[i] = {m_r[i][SW-1:0], FB'(0)} + DVW'(mroot >> 1);

    tfn_div u_div (
      .clk      (clk),
      .load     (div_load),
      .step     (div_step),
      .dividend (dvd[i]),
      .divisor  (mroot),
      .quo      (quo[i])
    );

    always_comb begin
      if (FB >= 16) begin
        pt_wide = PTW'(m_r[i][15:0]) << PSH;
      end else if (neg_r[i]) begin
        pt_wide = (PTW'(m_r[i][15:0]) + PTW'((1 << PSH) - 1)) >> PSH;
      end else begin
        pt_wide = PTW'(m_r[i][15:0]) >> PSH;
      end
      if (pt_wide > PTW'(1 << FB)) pt = QW'(1 << FB);
      else pt = pt_wide[QW-1:0];
      if (degen_r) qsel = pt;
      else if (quo[i] > QW'(1 << FB)) qsel = QW'(1 << FB);
      else qsel = quo[i];
      nrm[i] = neg_r[i] ? (~{1'b0, qsel} + NW'(1)) : {1'b0, qsel};
    end
  end

  assign in_ready       = (st_r == ST_IDLE);
  assign res_valid      = (st_r == ST_DONE);
  assign res.x          = nrm[0];
  assign res.y          = nrm[1];
  assign res.z          = nrm[2];
  assign res.degenerate = degen_r;

endmodule
